[hw/rtl/gmpr_pkg.sv]
// Package: field widths, request codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package gmpr_pkg;

  localparam int REQ_W   = 1;
  localparam int IDX_W   = 6;
  localparam int WALLS_W = 64;
  localparam int GSIZE_W = 7;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 1'b0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 1'b1;

  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd64;

  typedef struct packed {
    logic load_row;
    logic start_query;
    logic decide;
    logic sweep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic last;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/gmpr_if.sv]
// Stream interfaces for request and result transfers.
`timescale 1ns / 1ps
`default_nettype none
interface gmpr_req_if;
  logic                            valid;
  logic                            ready;
  logic [gmpr_pkg::REQ_W-1:0]      req_type;
  logic [gmpr_pkg::IDX_W-1:0]      row_index;
  logic [gmpr_pkg::WALLS_W-1:0]    row_walls;
  logic [gmpr_pkg::IDX_W-1:0]      src_row;
  logic [gmpr_pkg::IDX_W-1:0]      src_col;
  logic [gmpr_pkg::IDX_W-1:0]      dst_row;
  logic [gmpr_pkg::IDX_W-1:0]      dst_col;

  modport source (output valid, req_type, row_index, row_walls, src_row, src_col,
                  dst_row, dst_col, input ready);
  modport sink   (input valid, req_type, row_index, row_walls, src_row, src_col,
                  dst_row, dst_col, output ready);
endinterface

interface gmpr_rsp_if;
  logic valid;
  logic ready;
  logic is_reachable;

  modport source (output valid, is_reachable, input ready);
  modport sink   (input valid, is_reachable, output ready);
endinterface
`default_nettype wire

[hw/rtl/grid_monotone_path_reachability.sv]
// Top level: right/down grid path reachability over a loaded wall grid.
//
// A load transfer (req_type 0) writes one row of wall bits into the grid RAM
// and produces no result. A query transfer (req_type 1) yields one is_reachable
// result. Queries decided by their coordinates alone (cell outside the grid,
// same cell, destination above or left) go from DECIDE to FINISH; swept
// queries pass through SWEEP one grid row at a time, from src_row to dst_row,
// set by the single read port of the wall RAM and the row spread adder. Both
// kinds then wait in FINISH until the result register is free. Loads may
// be accepted while a result waits. grid_size is to be written through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module grid_monotone_path_reachability #(
  parameter int MAX_GRID = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [gmpr_pkg::GSIZE_W-1:0]  cfg_wdata,
  gmpr_req_if.sink                           in_chan,
  gmpr_rsp_if.source                         out_chan
);

  gmpr_pkg::cmd_t    cmd;
  gmpr_pkg::status_t status;

  gmpr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_req_type (in_chan.req_type),
    .in_ready    (in_chan.ready),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .status      (status),
    .cmd         (cmd)
  );

  gmpr_dp #(
    .MAX_GRID (MAX_GRID)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .row_index    (in_chan.row_index),
    .row_walls    (in_chan.row_walls),
    .src_row      (in_chan.src_row),
    .src_col      (in_chan.src_col),
    .dst_row      (in_chan.dst_row),
    .dst_col      (in_chan.dst_col),
    .cmd          (cmd),
    .status       (status),
    .is_reachable (out_chan.is_reachable)
  );

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.req_type == gmpr_pkg::REQ_LOAD) &&
     !out_chan.valid) |=> !out_chan.valid)
    else $error("load transfer produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.req_type == gmpr_pkg::REQ_QUERY))
    |=> !in_chan.ready)
    else $error("input ready while a query is in progress");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !cmd.emit) |=> !out_chan.valid)
    else $error("result repeated after transfer");

endmodule
`default_nettype wire

[hw/rtl/gmpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gmpr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/gmpr_ctrl.sv]
// Controller state machine: request sequencing and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module gmpr_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [gmpr_pkg::REQ_W-1:0]    in_req_type,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire gmpr_pkg::status_t             status,
  output gmpr_pkg::cmd_t                     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load_row    = in_xfer && (in_req_type == gmpr_pkg::REQ_LOAD);
    cmd.start_query = in_xfer && (in_req_type == gmpr_pkg::REQ_QUERY);
    cmd.decide      = (state_r == ST_DECIDE);
    cmd.sweep       = (state_r == ST_SWEEP);
    cmd.emit        = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start_query) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = status.early ? ST_FINISH : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (status.last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (cmd.emit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/gmpr_dp.sv]
// Datapath: wall RAM, query registers, row spread adder and result register.
`timescale 1ns / 1ps
`default_nettype none
module gmpr_dp #(
  parameter int MAX_GRID = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [gmpr_pkg::GSIZE_W-1:0]    cfg_wdata,
  input  wire logic [gmpr_pkg::IDX_W-1:0]      row_index,
  input  wire logic [gmpr_pkg::WALLS_W-1:0]    row_walls,
  input  wire logic [gmpr_pkg::IDX_W-1:0]      src_row,
  input  wire logic [gmpr_pkg::IDX_W-1:0]      src_col,
  input  wire logic [gmpr_pkg::IDX_W-1:0]      dst_row,
  input  wire logic [gmpr_pkg::IDX_W-1:0]      dst_col,
  input  wire gmpr_pkg::cmd_t                  cmd,
  output gmpr_pkg::status_t                    status,
  output logic                                 is_reachable
);

  localparam int AW = $clog2(MAX_GRID);
  localparam int GW = gmpr_pkg::GSIZE_W;
  localparam int IW = gmpr_pkg::IDX_W;

  logic [GW-1:0]       grid_size_r;
  logic [IW-1:0]       src_row_r, src_col_r, dst_row_r, dst_col_r;
  logic [MAX_GRID-1:0] colmask_r, colmask_nxt;
  logic [MAX_GRID-1:0] cur_r, cur_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic                res_r, res_nxt;
  logic                out_bit_r;

  logic [GW-1:0]       n_use;
  logic                oob, same, backward;
  logic [MAX_GRID-1:0] start_bit;
  logic [MAX_GRID-1:0] rd_row, free_cells, seed, spread;
  logic [MAX_GRID:0]   sum;
  logic                ram_we;
  logic [AW-1:0]       rd_addr;

  // clamp grid size to 1..MAX_GRID
  always_comb begin
    priority if (grid_size_r == '0) begin
      n_use = GW'(1);
    end else if (grid_size_r > GW'(MAX_GRID)) begin
      n_use = GW'(MAX_GRID);
    end else begin
      n_use = grid_size_r;
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_GRID; c++) begin
      colmask_nxt[c] = (GW'(c) < n_use);
      start_bit[c]   = (GW'(c) == {1'b0, src_col_r});
    end
  end

  assign oob = ({1'b0, src_row_r} >= n_use) || ({1'b0, src_col_r} >= n_use) ||
               ({1'b0, dst_row_r} >= n_use) || ({1'b0, dst_col_r} >= n_use);
  assign same     = (src_row_r == dst_row_r) && (src_col_r == dst_col_r);
  assign backward = (dst_row_r < src_row_r) || (dst_col_r < src_col_r);

  assign status.early = oob || same || backward;
  assign status.last  = cmd.sweep && (ptr_r == dst_row_r[AW-1:0]);

  assign ram_we  = cmd.load_row && ({1'b0, row_index} < GW'(MAX_GRID));
  assign rd_addr = cmd.decide ? src_row_r[AW-1:0] : ptr_r + AW'(1);

  gmpr_ram #(
    .WIDTH (MAX_GRID),
    .DEPTH (MAX_GRID)
  ) u_wall_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_index[AW-1:0]),
    .wdata (row_walls[MAX_GRID-1:0]),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  // carry chain of the add spreads each seed rightward through its free run
  assign free_cells = ~rd_row & colmask_r;
  assign seed       = cur_r & free_cells;
  assign sum        = {1'b0, free_cells} + {1'b0, seed};
  assign spread     = ((sum[MAX_GRID-1:0] ^ free_cells) & free_cells) | seed;

  always_comb begin
    cur_nxt = cur_r;
    ptr_nxt = ptr_r;
    res_nxt = res_r;
    if (cmd.decide) begin
      cur_nxt = start_bit;
      ptr_nxt = src_row_r[AW-1:0];
      res_nxt = !oob && same;
    end else if (cmd.sweep) begin
      cur_nxt = spread;
      ptr_nxt = ptr_r + AW'(1);
      res_nxt = spread[dst_col_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= gmpr_pkg::GSIZE_RESET;
      cur_r       <= '0;
    end else begin
      if (cfg_we) grid_size_r <= cfg_wdata;
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      src_row_r <= src_row;
      src_col_r <= src_col;
      dst_row_r <= dst_row;
      dst_col_r <= dst_col;
    end
    if (cmd.decide) colmask_r <= colmask_nxt;
    ptr_r <= ptr_nxt;
    res_r <= res_nxt;
    if (cmd.emit) out_bit_r <= res_r;
  end

  assign is_reachable = out_bit_r;

endmodule
`default_nettype wire

[dv/grid_monotone_path_reachability_test.sv]
// Testbench for the right/down grid reachability block: directed table, then random phases.
`timescale 1ns / 1ps
module grid_monotone_path_reachability_test;

  localparam int REQ_W   = gmpr_pkg::REQ_W;
  localparam int IDX_W   = gmpr_pkg::IDX_W;
  localparam int WALLS_W = gmpr_pkg::WALLS_W;
  localparam int GSIZE_W = gmpr_pkg::GSIZE_W;
  localparam logic [REQ_W-1:0]   REQ_LOAD    = gmpr_pkg::REQ_LOAD;
  localparam logic [REQ_W-1:0]   REQ_QUERY   = gmpr_pkg::REQ_QUERY;
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = gmpr_pkg::GSIZE_RESET;

  localparam int GRID_ROWS  = 64;
  localparam int WATCHDOG   = 1000;
  localparam int SETTLE_CYC = 8;
  localparam int TAIL_CYC   = 70;
  localparam int PHASE_ITEMS = 152;

  typedef struct {
    logic [REQ_W-1:0]   req_type;
    logic [IDX_W-1:0]   row_index;
    logic [WALLS_W-1:0] row_walls;
    logic [IDX_W-1:0]   src_row;
    logic [IDX_W-1:0]   src_col;
    logic [IDX_W-1:0]   dst_row;
    logic [IDX_W-1:0]   dst_col;
  } grid_req_t;

  typedef struct {
    bit                 set_size;
    logic [GSIZE_W-1:0] size_val;
    grid_req_t          req;
    bit                 typed;
    bit                 typed_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [GSIZE_W-1:0] cfg_wdata;

  gmpr_req_if req_ch ();
  gmpr_rsp_if rsp_ch ();

  grid_monotone_path_reachability #(.MAX_GRID(GRID_ROWS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (req_ch),
    .out_chan (rsp_ch)
  );

  always #4 clk = ~clk;

  logic [WALLS_W-1:0] wall_mem [GRID_ROWS];
  logic [GSIZE_W-1:0] gsize_shadow = GSIZE_RESET;
  bit                 reach_expected_q [$];
  int                 mismatch_cnt = 0;
  int                 quiet_cycles = 0;
  int                 src_pct = 0;
  int                 snk_pct = 0;
  stim_row_t          stim_tab [$];

  function automatic int size_in_use();
    if (gsize_shadow == 0) return 1;
    if (gsize_shadow > GRID_ROWS) return GRID_ROWS;
    return int'(gsize_shadow);
  endfunction

  function automatic bit path_exists(int sr, int sc, int dr, int dc);
    int n;
    int r;
    int k;
    logic [WALLS_W-1:0] cmask;
    logic [WALLS_W-1:0] cur;
    logic [WALLS_W-1:0] open_cells;
    n = size_in_use();
    cmask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    if (sr >= n || sc >= n || dr >= n || dc >= n) return 1'b0;
    if (sr == dr && sc == dc) return 1'b1;
    if (dr < sr || dc < sc) return 1'b0;
    if (wall_mem[sr][sc]) return 1'b0;
    cur = 64'd1 << sc;
    for (r = sr; r <= dr; r++) begin
      open_cells = ~wall_mem[r] & cmask;
      cur = cur & open_cells;
      for (k = 0; k < 64; k++) cur = cur | ((cur << 1) & open_cells);
    end
    return cur[dc];
  endfunction

  function automatic grid_req_t rand_fields();
    grid_req_t it;
    it.req_type  = REQ_LOAD;
    it.row_index = IDX_W'($urandom);
    it.row_walls = {$urandom, $urandom};
    it.src_row   = IDX_W'($urandom);
    it.src_col   = IDX_W'($urandom);
    it.dst_row   = IDX_W'($urandom);
    it.dst_col   = IDX_W'($urandom);
    return it;
  endfunction

  function automatic stim_row_t mk_load(int idx, logic [WALLS_W-1:0] walls);
    stim_row_t s;
    s = '{default: '0};
    s.req.req_type  = REQ_LOAD;
    s.req.row_index = IDX_W'(idx);
    s.req.row_walls = walls;
    return s;
  endfunction

  function automatic stim_row_t mk_query(int sr, int sc, int dr, int dc, bit typed, bit val);
    stim_row_t s;
    s = '{default: '0};
    s.req.req_type = REQ_QUERY;
    s.req.src_row  = IDX_W'(sr);
    s.req.src_col  = IDX_W'(sc);
    s.req.dst_row  = IDX_W'(dr);
    s.req.dst_col  = IDX_W'(dc);
    s.typed        = typed;
    s.typed_val    = val;
    return s;
  endfunction

  function automatic stim_row_t mk_size(int v);
    stim_row_t s;
    s = '{default: '0};
    s.set_size = 1'b1;
    s.size_val = GSIZE_W'(v);
    return s;
  endfunction

  function automatic grid_req_t gen_item();
    grid_req_t it;
    int n;
    int dens;
    it = rand_fields();
    n = size_in_use();
    if ($urandom_range(99) < 40) begin
      it.req_type = REQ_LOAD;
      if ($urandom_range(99) < 80) it.row_index = IDX_W'($urandom_range(n - 1));
      dens = $urandom_range(99);
      if (dens < 40)      it.row_walls = it.row_walls & {$urandom, $urandom} & {$urandom, $urandom};
      else if (dens < 75) it.row_walls = it.row_walls & {$urandom, $urandom};
      else if (dens < 95) it.row_walls = it.row_walls;
      else                it.row_walls = $urandom_range(1) ? '1 : '0;
    end else begin
      it.req_type = REQ_QUERY;
      if ($urandom_range(99) < 85) begin
        it.src_row = IDX_W'($urandom_range(n - 1));
        it.src_col = IDX_W'($urandom_range(n - 1));
        it.dst_row = IDX_W'($urandom_range(n - 1, int'(it.src_row)));
        it.dst_col = IDX_W'($urandom_range(n - 1, int'(it.src_col)));
      end
    end
    return it;
  endfunction

  // entered at a rising edge; returns at the edge of the transfer
  task automatic push_req(input grid_req_t it, input bit typed, input bit typed_val);
    while ($urandom_range(99) < src_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= it.req_type;
    req_ch.row_index <= it.row_index;
    req_ch.row_walls <= it.row_walls;
    req_ch.src_row   <= it.src_row;
    req_ch.src_col   <= it.src_col;
    req_ch.dst_row   <= it.dst_row;
    req_ch.dst_col   <= it.dst_col;
    @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
    if (it.req_type == REQ_LOAD) begin
      wall_mem[it.row_index] = it.row_walls;
    end else if (typed) begin
      reach_expected_q.push_back(typed_val);
    end else begin
      reach_expected_q.push_back(path_exists(int'(it.src_row), int'(it.src_col),
                                             int'(it.dst_row), int'(it.dst_col)));
    end
  endtask

  task automatic drain_block();
    req_ch.valid <= 1'b0;
    while (reach_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_size(input logic [GSIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gsize_shadow = v;
  endtask

  always @(posedge clk) rsp_ch.ready <= ($urandom_range(99) >= snk_pct);

  always @(negedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (reach_expected_q.size() == 0) begin
          $error("is_reachable: expected none, actual %0d", rsp_ch.is_reachable);
          mismatch_cnt++;
        end else if (reach_expected_q[0] !== rsp_ch.is_reachable) begin
          $error("is_reachable: expected %0d, actual %0d", reach_expected_q[0],
                 rsp_ch.is_reachable);
          mismatch_cnt++;
          void'(reach_expected_q.pop_front());
        end else begin
          void'(reach_expected_q.pop_front());
        end
      end
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int i;
    logic [GSIZE_W-1:0] phase_size [8];
    stim_row_t ld;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_LOAD;
    req_ch.row_index <= '0;
    req_ch.row_walls <= '0;
    req_ch.src_row   <= '0;
    req_ch.src_col   <= '0;
    req_ch.dst_row   <= '0;
    req_ch.dst_col   <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    for (i = 0; i < GRID_ROWS; i++) wall_mem[i] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every row gets written before any query can read it
    for (i = 0; i < GRID_ROWS; i++) begin
      ld = mk_load(i, '0);
      push_req(ld.req, 1'b0, 1'b0);
    end

    stim_tab.push_back(mk_query(0, 0, 63, 63, 1'b1, 1'b1));
    stim_tab.push_back(mk_load(5, '1));
    stim_tab.push_back(mk_query(0, 0, 63, 63, 1'b1, 1'b0));
    stim_tab.push_back(mk_query(5, 3, 5, 3, 1'b1, 1'b1));
    stim_tab.push_back(mk_query(5, 3, 6, 3, 1'b1, 1'b0));
    stim_tab.push_back(mk_query(10, 10, 9, 20, 1'b1, 1'b0));
    stim_tab.push_back(mk_query(10, 10, 20, 9, 1'b1, 1'b0));
    stim_tab.push_back(mk_query(63, 63, 63, 63, 1'b1, 1'b1));
    stim_tab.push_back(mk_load(0, 64'h8000_0000_0000_0000));
    stim_tab.push_back(mk_query(0, 0, 0, 63, 1'b0, 1'b0));
    stim_tab.push_back(mk_query(0, 0, 1, 63, 1'b0, 1'b0));
    stim_tab.push_back(mk_load(7, 64'hAAAA_AAAA_AAAA_AAAA));
    stim_tab.push_back(mk_query(6, 0, 7, 62, 1'b0, 1'b0));
    stim_tab.push_back(mk_load(63, 64'h5555_5555_5555_5555));
    stim_tab.push_back(mk_query(62, 1, 63, 63, 1'b0, 1'b0));
    stim_tab.push_back(mk_size(0));
    stim_tab.push_back(mk_query(0, 0, 0, 0, 1'b1, 1'b1));
    stim_tab.push_back(mk_query(0, 0, 0, 1, 1'b1, 1'b0));
    stim_tab.push_back(mk_query(1, 1, 1, 1, 1'b1, 1'b0));
    stim_tab.push_back(mk_size(127));
    stim_tab.push_back(mk_query(63, 63, 63, 63, 1'b1, 1'b1));
    stim_tab.push_back(mk_query(0, 0, 4, 62, 1'b0, 1'b0));
    stim_tab.push_back(mk_size(8));
    stim_tab.push_back(mk_query(0, 0, 7, 7, 1'b0, 1'b0));
    stim_tab.push_back(mk_query(8, 8, 8, 8, 1'b1, 1'b0));
    stim_tab.push_back(mk_query(0, 0, 8, 0, 1'b1, 1'b0));

    foreach (stim_tab[j]) begin
      if (stim_tab[j].set_size) begin
        drain_block();
        write_size(stim_tab[j].size_val);
      end else begin
        push_req(stim_tab[j].req, stim_tab[j].typed, stim_tab[j].typed_val);
      end
    end

    phase_size[0] = 7'd64;
    phase_size[1] = 7'd1;
    phase_size[2] = 7'd127;
    phase_size[3] = 7'd2;
    phase_size[4] = 7'd0;
    phase_size[5] = GSIZE_W'($urandom_range(3, 63));
    phase_size[6] = 7'd65;
    phase_size[7] = GSIZE_W'($urandom_range(3, 63));

    for (ph = 0; ph < 8; ph++) begin
      drain_block();
      write_size(phase_size[ph]);
      case (ph % 4)
        0: begin src_pct = 0;  snk_pct = 0;  end
        1: begin src_pct = 71; snk_pct = 0;  end
        2: begin src_pct = 0;  snk_pct = 71; end
        default: begin src_pct = 13; snk_pct = 13; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) push_req(gen_item(), 1'b0, 1'b0);
    end

    req_ch.valid <= 1'b0;
    while (reach_expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
